/* design/sfd_pkg.sv */
// Shared types and constants for the serial frame deframer.
// No dependencies; used by sfd_parse, sfd_emit, the top module and the testbench.
package sfd_pkg;

   localparam int unsigned ADDR_BYTES = 6;
   localparam int unsigned HDR_BYTES  = 7;
   localparam int unsigned IDLE_W     = 17;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KIND      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT = 2'd3;

   localparam logic [7:0]  SYNC_RESET      = 8'd170;
   localparam logic [7:0]  VERSION_RESET   = 8'd1;
   localparam logic [7:0]  KIND_RESET      = 8'd1;
   localparam logic [15:0] GAP_LIMIT_RESET = 16'd100;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Frame end event from the parser to the result sequencer.
   typedef struct packed {
      logic        fire;
      logic        bad;
      logic [47:0] addr;
      logic [7:0]  len;
      logic [7:0]  ack;
   } frame_done_type;

endpackage

/* design/sfd_store.sv */
// Frame byte store: single-port-write, single-port-read synchronous memory.
// Read data is registered. Depends on nothing.
module sfd_store #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sfd_parse.sv */
// Frame parser: sync/version/type hunt, header capture, checksum, gap timeout.
// Writes frame bytes into sfd_store; uses sfd_pkg.
module sfd_parse #(
   parameter int unsigned BUFFER_BYTES = 64,
   parameter int unsigned AW           = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_take,
   input  logic                  tick_take,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            sync_value,
   input  logic [7:0]            version_value,
   input  logic [7:0]            frame_kind_value,
   input  logic [15:0]           gap_limit_ticks,
   output logic                  mem_we,
   output logic [AW-1:0]         mem_waddr,
   output logic [7:0]            mem_wdata,
   output logic                  in_check,
   output sfd_pkg::frame_done_type done
);

   localparam int unsigned SCW = $clog2(BUFFER_BYTES + 1);
   localparam int unsigned EW  = (SCW > 9) ? SCW : 9;

   localparam logic [2:0] PH_SYNC    = 3'd0;
   localparam logic [2:0] PH_VERSION = 3'd1;
   localparam logic [2:0] PH_TYPE    = 3'd2;
   localparam logic [2:0] PH_DATA    = 3'd3;
   localparam logic [2:0] PH_CHECK   = 3'd4;

   logic [2:0]                  phase_ff, phase_in;
   logic [7:0]                  xor_ff, xor_in;
   logic [SCW-1:0]              stored_ff, stored_in;
   logic [EW-1:0]               expected_ff, expected_in;
   logic [sfd_pkg::IDLE_W-1:0]  idle_ff, idle_in;
   logic [47:0]                 addr_ff, addr_in;
   logic [7:0]                  len_ff, len_in;

   logic           timed_out;
   logic [2:0]     phase_eff;
   logic [SCW-1:0] stored_eff;
   logic [SCW-1:0] stored_new;
   logic [EW-1:0]  expected_eff;
   logic [EW-1:0]  expected_new;
   logic           len_byte;

   always_comb begin
      timed_out    = (phase_ff != PH_SYNC) &&
                     ({1'b0, gap_limit_ticks} < idle_ff);
      phase_eff    = timed_out ? PH_SYNC : phase_ff;
      stored_eff   = timed_out ? '0 : stored_ff;
      expected_eff = timed_out ? '0 : expected_ff;
      stored_new   = stored_eff + SCW'(1);
      len_byte     = (stored_eff == SCW'(sfd_pkg::ADDR_BYTES));
      expected_new = len_byte ? (EW'(sfd_pkg::HDR_BYTES) + EW'(rx_byte)) : expected_eff;

      phase_in    = phase_ff;
      xor_in      = xor_ff;
      stored_in   = stored_ff;
      expected_in = expected_ff;
      idle_in     = idle_ff;
      addr_in     = addr_ff;
      len_in      = len_ff;
      mem_we      = 1'b0;
      mem_waddr   = stored_eff[AW-1:0];
      mem_wdata   = rx_byte;
      done        = '0;
      done.addr   = addr_ff;
      done.len    = len_ff;
      done.ack    = xor_ff;

      if (tick_take) begin
         if (idle_ff != '1) begin
            idle_in = idle_ff + sfd_pkg::IDLE_W'(1);
         end
      end else if (byte_take) begin
         idle_in     = '0;
         phase_in    = phase_eff;
         stored_in   = stored_eff;
         expected_in = expected_eff;
         unique case (phase_eff)
            PH_VERSION: begin
               phase_in = (rx_byte == version_value) ? PH_TYPE : PH_SYNC;
            end
            PH_TYPE: begin
               xor_in      = version_value ^ rx_byte;
               stored_in   = '0;
               expected_in = '0;
               phase_in    = (rx_byte == frame_kind_value) ? PH_DATA : PH_SYNC;
            end
            PH_DATA: begin
               if (stored_eff >= SCW'(BUFFER_BYTES)) begin
                  phase_in    = PH_SYNC;
                  stored_in   = '0;
                  expected_in = '0;
               end else begin
                  mem_we    = 1'b1;
                  stored_in = stored_new;
                  xor_in    = xor_ff ^ rx_byte;
                  if (stored_eff < SCW'(sfd_pkg::ADDR_BYTES)) begin
                     addr_in = {addr_ff[39:0], rx_byte};
                  end
                  if (len_byte) begin
                     len_in = rx_byte;
                  end
                  expected_in = expected_new;
                  // frame too long for the store: drop it
                  if (len_byte && (expected_new > EW'(BUFFER_BYTES))) begin
                     phase_in    = PH_SYNC;
                     stored_in   = '0;
                     expected_in = '0;
                  end else if ((expected_new != '0) &&
                               (EW'(stored_new) == expected_new)) begin
                     phase_in = PH_CHECK;
                  end
               end
            end
            PH_CHECK: begin
               phase_in  = PH_SYNC;
               done.fire = 1'b1;
               done.bad  = (rx_byte != xor_ff);
            end
            default: begin
               phase_in = (rx_byte == sync_value) ? PH_VERSION : PH_SYNC;
            end
         endcase
      end
   end

   assign in_check = (phase_ff == PH_CHECK);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC;
         xor_ff      <= '0;
         stored_ff   <= '0;
         expected_ff <= '0;
         idle_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         xor_ff      <= xor_in;
         stored_ff   <= stored_in;
         expected_ff <= expected_in;
         idle_ff     <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      len_ff  <= len_in;
   end

endmodule

/* design/sfd_emit.sv */
// Result sequencer: walks the stored payload through the memory read port
// and holds each result in the output register. Uses sfd_pkg.
module sfd_emit #(
   parameter int unsigned AW = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sfd_pkg::frame_done_type done,
   input  logic [7:0]              rd_data,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   output logic                    busy,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_status,
   output logic [47:0]             rsp_dest_address,
   output logic [5:0]              rsp_payload_length,
   output logic [5:0]              rsp_byte_index,
   output logic [7:0]              rsp_payload_value,
   output logic                    rsp_has_byte,
   output logic [7:0]              rsp_ack_value,
   output logic                    rsp_last
);

   logic          valid_ff, valid_in;
   logic          pend_ff, pend_in;
   logic [7:0]    rem_ff, rem_in;
   logic [7:0]    idx_ff, idx_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic          status_ff, status_in;
   logic [47:0]   dest_ff, dest_in;
   logic [5:0]    len_ff, len_in;
   logic          has_ff, has_in;
   logic [7:0]    ack_ff, ack_in;
   logic          last_ff, last_in;

   logic take;
   logic start;

   always_comb begin
      take  = valid_ff && !rsp_stall;
      start = done.fire && !done.bad && (done.len != '0);

      valid_in  = valid_ff;
      pend_in   = 1'b0;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      raddr_in  = raddr_ff;
      status_in = status_ff;
      dest_in   = dest_ff;
      len_in    = len_ff;
      has_in    = has_ff;
      ack_in    = ack_ff;
      last_in   = last_ff;
      rd_en     = 1'b0;
      rd_addr   = raddr_ff + AW'(1);

      if (take) begin
         valid_in = 1'b0;
      end
      // read data lands in the store's output register this cycle
      if (pend_ff) begin
         valid_in = 1'b1;
      end

      if (done.fire) begin
         status_in = done.bad;
         dest_in   = done.bad ? '0 : done.addr;
         len_in    = done.bad ? '0 : done.len[5:0];
         ack_in    = done.bad ? '0 : done.ack;
         idx_in    = '0;
         has_in    = start;
         if (start) begin
            rd_en    = 1'b1;
            rd_addr  = AW'(sfd_pkg::HDR_BYTES);
            raddr_in = AW'(sfd_pkg::HDR_BYTES);
            pend_in  = 1'b1;
            rem_in   = done.len - 8'd1;
            last_in  = (done.len == 8'd1);
         end else begin
            valid_in = 1'b1;
            last_in  = 1'b1;
         end
      end else if (take && (rem_ff != '0)) begin
         rd_en    = 1'b1;
         raddr_in = rd_addr;
         pend_in  = 1'b1;
         rem_in   = rem_ff - 8'd1;
         idx_in   = idx_ff + 8'd1;
         last_in  = (rem_ff == 8'd1);
      end
   end

   assign busy               = (rem_ff != '0) || pend_ff;
   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_dest_address   = dest_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_byte_index     = idx_ff[5:0];
   assign rsp_payload_value  = has_ff ? rd_data : 8'd0;
   assign rsp_has_byte       = has_ff;
   assign rsp_ack_value      = ack_ff;
   assign rsp_last           = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
         rem_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      raddr_ff  <= raddr_in;
      status_ff <= status_in;
      dest_ff   <= dest_in;
      len_ff    <= len_in;
      has_ff    <= has_in;
      ack_ff    <= ack_in;
      last_ff   <= last_in;
   end

endmodule

/* design/serial_frame_deframer_xor_check.sv */
// Serial frame deframer with XOR check. Every input transfer (a byte or a
// tick) is taken in the cycle it is presented unless req_stall is high. The
// frame bytes go into a BUFFER_BYTES-deep store with one write and one
// registered read port; after a good checksum the L payload bytes come back
// out of that read port one at a time (read, then output register), and the
// next read starts only once the current result is taken. From the cycle after
// the checksum transfer, req_stall stays high until the final result has been
// loaded into the output register, and also while a result is still waiting
// and the next byte would be a checksum byte. Error results and zero-length
// results come straight from the output register.
// Depends on sfd_pkg, sfd_store, sfd_parse and sfd_emit.
module serial_frame_deframer_xor_check #(
   parameter int unsigned BUFFER_BYTES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_status,
   output logic [47:0]                    rsp_dest_address,
   output logic [5:0]                     rsp_payload_length,
   output logic [5:0]                     rsp_byte_index,
   output logic [7:0]                     rsp_payload_value,
   output logic                           rsp_has_byte,
   output logic [7:0]                     rsp_ack_value,
   output logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   localparam int unsigned AW = $clog2(BUFFER_BYTES);

   logic [7:0]  sync_ff;
   logic [7:0]  version_ff;
   logic [7:0]  kind_ff;
   logic [15:0] gap_ff;

   logic                    take;
   logic                    byte_take;
   logic                    tick_take;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [7:0]              mem_wdata;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [7:0]              rd_data;
   logic                    in_check;
   logic                    emit_busy;
   sfd_pkg::frame_done_type done;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= sfd_pkg::SYNC_RESET;
         version_ff <= sfd_pkg::VERSION_RESET;
         kind_ff    <= sfd_pkg::KIND_RESET;
         gap_ff     <= sfd_pkg::GAP_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sfd_pkg::CSR_SYNC:      sync_ff    <= csr_wr_data[7:0];
            sfd_pkg::CSR_VERSION:   version_ff <= csr_wr_data[7:0];
            sfd_pkg::CSR_KIND:      kind_ff    <= csr_wr_data[7:0];
            sfd_pkg::CSR_GAP_LIMIT: gap_ff     <= csr_wr_data[15:0];
         endcase
      end
   end

   // a checksum byte must not arrive while the previous result is unsent
   assign req_stall = emit_busy || (rsp_valid && in_check);
   assign take      = req_valid && !req_stall;
   assign byte_take = take && (req_operation == sfd_pkg::OP_BYTE);
   assign tick_take = take && (req_operation == sfd_pkg::OP_TICK);

   sfd_parse #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .AW           (AW)
   ) u_parse (
      .clock            (clock),
      .reset            (reset),
      .byte_take        (byte_take),
      .tick_take        (tick_take),
      .rx_byte          (req_rx_byte),
      .sync_value       (sync_ff),
      .version_value    (version_ff),
      .frame_kind_value (kind_ff),
      .gap_limit_ticks  (gap_ff),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .in_check         (in_check),
      .done             (done)
   );

   sfd_store #(
      .DEPTH (BUFFER_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfd_emit #(
      .AW (AW)
   ) u_emit (
      .clock              (clock),
      .reset              (reset),
      .done               (done),
      .rd_data            (rd_data),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .busy               (emit_busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_value  (rsp_payload_value),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_ack_value      (rsp_ack_value),
      .rsp_last           (rsp_last)
   );

endmodule

/* dv/serial_frame_deframer_xor_check_tb.sv */
`timescale 1ns / 1ps
// Testbench for serial_frame_deframer_xor_check: sends bytes and ticks, predicts
// every result frame with a small tracker class and checks results field by field.
// Depends on sfd_pkg and the serial_frame_deframer_xor_check RTL.
module serial_frame_deframer_xor_check_tb;

   localparam int unsigned STORE_DEPTH   = 64;
   localparam int unsigned MAX_PAYLOAD   = STORE_DEPTH - sfd_pkg::HDR_BYTES;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 16;

   typedef enum logic [2:0] {
      HUNT, WANT_VERSION, WANT_KIND, TAKE_DATA, WANT_CHECK
   } parse_phase_type;

   typedef enum int unsigned {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   typedef struct packed {
      logic        status;
      logic [47:0] dest_address;
      logic [5:0]  payload_length;
      logic [5:0]  byte_index;
      logic [7:0]  payload_value;
      logic        has_byte;
      logic [7:0]  ack_value;
      logic        last;
   } frame_result_type;

   // Tracks parser state and configuration, holds the results still owed.
   class frame_tracker;
      logic [7:0]                 sync_byte;
      logic [7:0]                 version_byte;
      logic [7:0]                 kind_byte;
      logic [15:0]                gap_limit;
      parse_phase_type            phase;
      logic [7:0]                 xor_acc;
      int unsigned                stored;
      int unsigned                expected_len;
      logic [7:0]                 frame_bytes [STORE_DEPTH];
      logic [sfd_pkg::IDLE_W-1:0] idle_ticks;
      frame_result_type           pending_results [$];
      int unsigned                errors;

      function new();
         sync_byte    = sfd_pkg::SYNC_RESET;
         version_byte = sfd_pkg::VERSION_RESET;
         kind_byte    = sfd_pkg::KIND_RESET;
         gap_limit    = sfd_pkg::GAP_LIMIT_RESET;
         xor_acc      = '0;
         idle_ticks   = '0;
         errors       = 0;
         go_hunt();
      endfunction

      function void go_hunt();
         phase        = HUNT;
         stored       = 0;
         expected_len = 0;
      endfunction

      function void write_reg(logic [sfd_pkg::CSR_IDX_W-1:0] idx,
                              logic [sfd_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            sfd_pkg::CSR_SYNC:      sync_byte    = data[7:0];
            sfd_pkg::CSR_VERSION:   version_byte = data[7:0];
            sfd_pkg::CSR_KIND:      kind_byte    = data[7:0];
            sfd_pkg::CSR_GAP_LIMIT: gap_limit    = data;
            default: ;
         endcase
      endfunction

      function void emit_frame();
         frame_result_type r;
         logic [47:0]      addr;
         int unsigned      len;
         addr = '0;
         for (int i = 0; i < sfd_pkg::ADDR_BYTES; i++) addr = {addr[39:0], frame_bytes[i]};
         len = 32'(frame_bytes[sfd_pkg::ADDR_BYTES]);
         r = '0;
         r.dest_address   = addr;
         r.payload_length = 6'(len);
         r.ack_value      = xor_acc;
         if (len == 0) begin
            r.last = 1'b1;
            pending_results.push_back(r);
            return;
         end
         for (int i = 0; i < len && sfd_pkg::HDR_BYTES + i < STORE_DEPTH; i++) begin
            r.byte_index    = 6'(i);
            r.payload_value = frame_bytes[sfd_pkg::HDR_BYTES + i];
            r.has_byte      = 1'b1;
            r.last          = (i + 1 == len);
            pending_results.push_back(r);
         end
      endfunction

      function void take_item(logic op, logic [7:0] b);
         frame_result_type r;
         if (op == sfd_pkg::OP_TICK) begin
            if (idle_ticks != '1) idle_ticks++;
            return;
         end
         // stale frame: drop it, then treat this byte as a hunt byte
         if (phase != HUNT && idle_ticks > {1'b0, gap_limit}) go_hunt();
         idle_ticks = '0;
         case (phase)
            WANT_VERSION: begin
               if (b == version_byte) phase = WANT_KIND;
               else go_hunt();
            end
            WANT_KIND: begin
               xor_acc      = version_byte ^ b;
               stored       = 0;
               expected_len = 0;
               if (b == kind_byte) phase = TAKE_DATA;
               else go_hunt();
            end
            TAKE_DATA: begin
               if (stored >= STORE_DEPTH) begin
                  go_hunt();
                  return;
               end
               frame_bytes[stored] = b;
               stored++;
               xor_acc ^= b;
               if (stored >= sfd_pkg::HDR_BYTES && expected_len == 0) begin
                  expected_len = sfd_pkg::HDR_BYTES +
                                 32'(frame_bytes[sfd_pkg::ADDR_BYTES]);
                  if (expected_len > STORE_DEPTH) begin
                     go_hunt();
                     return;
                  end
               end
               if (expected_len != 0 && stored == expected_len) phase = WANT_CHECK;
            end
            WANT_CHECK: begin
               phase = HUNT;
               if (b != xor_acc) begin
                  r = '0;
                  r.status = 1'b1;
                  r.last   = 1'b1;
                  pending_results.push_back(r);
               end else begin
                  emit_frame();
               end
            end
            default: phase = (b == sync_byte) ? WANT_VERSION : HUNT;
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
      endtask

      task check_result(frame_result_type got);
         frame_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result with none pending (byte_index %0d)", got.byte_index));
            return;
         end
         want = pending_results.pop_front();
         check_field("status", 64'(got.status), 64'(want.status));
         check_field("dest_address", 64'(got.dest_address), 64'(want.dest_address));
         check_field("payload_length", 64'(got.payload_length), 64'(want.payload_length));
         check_field("byte_index", 64'(got.byte_index), 64'(want.byte_index));
         check_field("payload_value", 64'(got.payload_value), 64'(want.payload_value));
         check_field("has_byte", 64'(got.has_byte), 64'(want.has_byte));
         check_field("ack_value", 64'(got.ack_value), 64'(want.ack_value));
         check_field("last", 64'(got.last), 64'(want.last));
      endtask
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_operation = sfd_pkg::OP_BYTE;
   logic [7:0]                     req_rx_byte = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_status;
   logic [47:0]                    rsp_dest_address;
   logic [5:0]                     rsp_payload_length;
   logic [5:0]                     rsp_byte_index;
   logic [7:0]                     rsp_payload_value;
   logic                           rsp_has_byte;
   logic [7:0]                     rsp_ack_value;
   logic                           rsp_last;
   logic                           csr_wr_en = 1'b0;
   logic [sfd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sfd_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   frame_tracker tracker;
   int unsigned  cycle_count = 0;
   int unsigned  items_sent = 0;
   int unsigned  burst_left = 0;
   bit           fast_mode = 1'b0;
   int unsigned  stall_span = 0;
   int unsigned  stall_mode = 0;

   serial_frame_deframer_xor_check #(.BUFFER_BYTES(STORE_DEPTH)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_value  (rsp_payload_value),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_ack_value      (rsp_ack_value),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("serial_frame_deframer_xor_check_tb failed");
         $finish;
      end
   end

   // receiver: switches between free-running, light, periodic and heavy stall
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_span <= $urandom_range(20, 200);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= stall_span[3];
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) tracker.take_item(req_operation, req_rx_byte);
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(frame_result_type'({rsp_status, rsp_dest_address,
            rsp_payload_length, rsp_byte_index, rsp_payload_value, rsp_has_byte,
            rsp_ack_value, rsp_last}));
   end

   task automatic send_item(input logic op, input logic [7:0] b);
      int unsigned gap;
      if (!fast_mode) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_rx_byte   <= b;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(sfd_pkg::OP_BYTE, b);
   endtask

   task automatic send_ticks(input int unsigned n);
      fast_mode = (n > 1000);
      repeat (n) send_item(sfd_pkg::OP_TICK, 8'($urandom));
      fast_mode = 1'b0;
   endtask

   // a few ticks between frame bytes, never enough to go stale
   task automatic pace_ticks();
      if (tracker.gap_limit != 0 && $urandom_range(0, 7) == 0)
         send_ticks($urandom_range(1, tracker.gap_limit < 3 ? tracker.gap_limit : 3));
   endtask

   function automatic logic [7:0] fill_byte(fill_type fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom);
      endcase
   endfunction

   // hold_ticks are placed between the version and type bytes
   task automatic send_frame(input int unsigned len, input bit good_sum, input fill_type fill,
                             input int unsigned hold_ticks);
      logic [7:0]  body [$];
      logic [7:0]  sum;
      int unsigned n_payload;
      n_payload = (len > MAX_PAYLOAD) ? $urandom_range(0, 4) : len;
      body.push_back(tracker.version_byte);
      body.push_back(tracker.kind_byte);
      for (int i = 0; i < sfd_pkg::ADDR_BYTES; i++) body.push_back(fill_byte(fill));
      body.push_back(8'(len));
      for (int i = 0; i < n_payload; i++) body.push_back(fill_byte(fill));
      sum = '0;
      foreach (body[i]) sum ^= body[i];
      body.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
      send_byte(tracker.sync_byte);
      send_byte(body[0]);
      send_ticks(hold_ticks);
      for (int i = 1; i < body.size(); i++) begin
         if (i > 1 || hold_ticks == 0) pace_ticks();
         send_byte(body[i]);
      end
   endtask

   task automatic send_bad_header(input bit bad_version);
      send_byte(tracker.sync_byte);
      if (bad_version) begin
         send_byte(tracker.version_byte ^ 8'($urandom_range(1, 255)));
      end else begin
         send_byte(tracker.version_byte);
         send_byte(tracker.kind_byte ^ 8'($urandom_range(1, 255)));
      end
   endtask

   // frame cut short, then a silence just past the gap limit
   task automatic send_stale_frame();
      int unsigned k;
      k = $urandom_range(1, 10);
      send_byte(tracker.sync_byte);
      if (k > 1) send_byte(tracker.version_byte);
      if (k > 2) send_byte(tracker.kind_byte);
      for (int i = 3; i < k; i++) send_byte(8'($urandom));
      send_ticks(32'(tracker.gap_limit) + 1 + $urandom_range(0, 2));
   endtask

   task automatic send_noise(input int unsigned n);
      repeat (n) send_byte(8'($urandom));
   endtask

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 6);
      if (r < 85) return $urandom_range(7, 20);
      if (r < 93) return $urandom_range(40, MAX_PAYLOAD);
      return $urandom_range(MAX_PAYLOAD + 1, 255);
   endfunction

   task automatic run_random(input int unsigned n);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) send_frame(pick_length(), $urandom_range(0, 6) != 0, FILL_RANDOM, 0);
         else if (pick < 73) send_bad_header($urandom_range(0, 1) != 0);
         else if (pick < 81 && tracker.gap_limit <= 200) send_stale_frame();
         else if (pick < 90) send_noise($urandom_range(1, 6));
         else send_ticks($urandom_range(1, 12));
      end
   endtask

   // wait until every owed result has been seen, then let the parser go quiet
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tracker.pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sfd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sfd_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   // upper data bits of the byte registers are junk on purpose
   task automatic set_config(input logic [7:0] sync_b, input logic [7:0] version_b,
                             input logic [7:0] kind_b, input logic [15:0] gap);
      write_csr(sfd_pkg::CSR_SYNC, {8'($urandom), sync_b});
      write_csr(sfd_pkg::CSR_VERSION, {8'($urandom), version_b});
      write_csr(sfd_pkg::CSR_KIND, {8'($urandom), kind_b});
      write_csr(sfd_pkg::CSR_GAP_LIMIT, gap);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: sync 170, version 1, type 1, gap 100
      send_ticks(3);
      send_frame(0, 1'b1, FILL_ZERO, 0);
      send_frame(1, 1'b1, FILL_ONES, 0);
      send_frame(MAX_PAYLOAD, 1'b1, FILL_ONES, 0);
      send_frame(4, 1'b0, FILL_RANDOM, 0);
      send_frame(0, 1'b0, FILL_RANDOM, 0);
      send_bad_header(1'b1);
      send_bad_header(1'b0);
      send_frame(MAX_PAYLOAD + 1, 1'b1, FILL_RANDOM, 0);
      send_frame(255, 1'b1, FILL_ONES, 0);
      send_frame(2, 1'b1, FILL_RANDOM, 0);
      settle();

      // zero gap limit: any tick mid-frame drops the frame
      set_config(8'h00, 8'hFF, 8'h00, 16'd0);
      send_frame(2, 1'b1, FILL_RANDOM, 0);
      send_stale_frame();
      run_random(30);
      settle();

      // widest gap limit: a long hold mid-frame stays inside the limit
      set_config(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
      send_frame(5, 1'b1, FILL_RANDOM, 0);
      send_frame(3, 1'b1, FILL_RANDOM, 20);
      run_random(30);
      settle();

      // small gap limit: hold exactly at the limit, then one past it
      set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(1, 8)));
      send_frame(3, 1'b1, FILL_RANDOM, 32'(tracker.gap_limit));
      send_frame(3, 1'b1, FILL_RANDOM, 32'(tracker.gap_limit) + 1);
      send_stale_frame();
      run_random(40);
      settle();

      set_config(sfd_pkg::SYNC_RESET, sfd_pkg::VERSION_RESET, sfd_pkg::KIND_RESET,
                 sfd_pkg::GAP_LIMIT_RESET);
      run_random(30);
      settle();

      if (tracker.errors == 0 && tracker.pending_results.size() == 0)
         $display("serial_frame_deframer_xor_check_tb passed");
      else
         $display("serial_frame_deframer_xor_check_tb failed");
      $finish;
   end

endmodule
